>>> design/scmt_pkg.sv
// Shared types and constants for the star candidate merge table.
// No dependencies; imported by the merge unit, the top level and the checker.
package scmt_pkg;

    // Width of a radius, both in the table and at the ports.
    localparam int RADIUS_BITS = 8;

    // What the merge unit did with the entry leaving its last stage.
    typedef struct packed {
        logic record;   // entry was merged into or appended
        logic merge;    // 1: merged, 0: appended
    } scmt_event_t;

endpackage

>>> design/scmt_cell.sv
// One table cell of the rotating ring: holds a single packed entry and passes
// it to its neighbor whenever the ring advances. No package dependency.
module scmt_cell #(
    parameter int ENTRY_BITS = 52
) (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [ENTRY_BITS-1:0] d_in,
    output logic [ENTRY_BITS-1:0] q_out
);

    logic [ENTRY_BITS-1:0] entry_reg;
    logic [ENTRY_BITS-1:0] entry_next;

    assign entry_next = shift_en ? d_in : entry_reg;

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q_out = entry_reg;

endmodule

>>> design/scmt_merge_unit.sv
// Three-stage compare/merge unit that sits inside the cell ring.
// Depends on scmt_pkg (RADIUS_BITS, scmt_event_t).
module scmt_merge_unit #(
    parameter int STAR_SLOTS = 1024,
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 8,
    localparam int CB = COORD_BITS + FRAC_BITS,
    localparam int IW = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1,
    localparam int CW = $clog2(STAR_SLOTS + 1),
    localparam int EW = 2 * CB + scmt_pkg::RADIUS_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic                           adv,
    input  logic                           feed_vld,
    input  logic [IW-1:0]                  feed_idx,
    input  logic [EW-1:0]                  feed_entry,
    input  logic [CB-1:0]                  cand_x,
    input  logic [CB-1:0]                  cand_y,
    input  logic [scmt_pkg::RADIUS_BITS-1:0] cand_r,
    input  logic [CW-1:0]                  count,
    output logic [EW-1:0]                  out_entry,
    output scmt_pkg::scmt_event_t          ev,
    output logic [IW-1:0]                  ev_idx
);
    import scmt_pkg::*;

    localparam int RB  = RADIUS_BITS;
    localparam int RFW = RB + FRAC_BITS;

    // stage 1: raw entry from the head cell
    logic          s1_vld_reg, s1_vld_next;
    logic [IW-1:0] s1_idx_reg;
    logic [EW-1:0] s1_entry_reg;

    // stage 2: distances and bounding-box check
    logic           s2_vld_reg, s2_vld_next;
    logic [IW-1:0]  s2_idx_reg;
    logic [EW-1:0]  s2_entry_reg;
    logic [RFW-1:0] s2_dx_reg, s2_dy_reg, s2_rfix_reg;
    logic [RB-1:0]  s2_big_reg;
    logic           s2_near_reg;

    // stage 3: squares
    logic             s3_vld_reg, s3_vld_next;
    logic [IW-1:0]    s3_idx_reg;
    logic [EW-1:0]    s3_entry_reg;
    logic [2*RFW-1:0] s3_dx2_reg, s3_dy2_reg, s3_r2_reg;
    logic [RB-1:0]    s3_big_reg;
    logic             s3_near_reg;

    logic hit_reg, hit_next;

    // stage 1 combinational
    logic [CB-1:0]  e1_cx, e1_cy;
    logic [RB-1:0]  e1_r;
    logic [RB-1:0]  big1;
    logic [RFW-1:0] rfix1;
    logic [CB-1:0]  dx1, dy1;
    logic           near1;

    assign {e1_cx, e1_cy, e1_r} = s1_entry_reg;
    assign big1  = (e1_r > cand_r) ? e1_r : cand_r;
    assign rfix1 = RFW'(big1) << FRAC_BITS;
    assign dx1   = (cand_x >= e1_cx) ? cand_x - e1_cx : e1_cx - cand_x;
    assign dy1   = (cand_y >= e1_cy) ? cand_y - e1_cy : e1_cy - cand_y;
    assign near1 = (dx1 <= CB'(rfix1)) && (dy1 <= CB'(rfix1));

    // stage 2 combinational
    logic [2*RFW-1:0] dx2, dy2, r2;
    assign dx2 = {{RFW{1'b0}}, s2_dx_reg} * {{RFW{1'b0}}, s2_dx_reg};
    assign dy2 = {{RFW{1'b0}}, s2_dy_reg} * {{RFW{1'b0}}, s2_dy_reg};
    assign r2  = {{RFW{1'b0}}, s2_rfix_reg} * {{RFW{1'b0}}, s2_rfix_reg};

    // stage 3 combinational: decide and rewrite the entry
    logic [CB-1:0]  e3_cx, e3_cy;
    logic [2*RFW:0] sq_sum;
    logic           within3, in_tbl, at_tail, do_merge, do_append;
    logic [CB:0]    sum_x, sum_y;

    assign e3_cx     = s3_entry_reg[EW-1 -: CB];
    assign e3_cy     = s3_entry_reg[EW-CB-1 -: CB];
    assign sq_sum    = {1'b0, s3_dx2_reg} + {1'b0, s3_dy2_reg};
    assign within3   = s3_near_reg && (sq_sum <= {1'b0, s3_r2_reg});
    assign in_tbl    = CW'(s3_idx_reg) < count;
    assign at_tail   = CW'(s3_idx_reg) == count;
    assign do_merge  = s3_vld_reg && in_tbl && !hit_reg && within3;
    assign do_append = s3_vld_reg && at_tail && !hit_reg;
    assign sum_x     = {1'b0, e3_cx} + {1'b0, cand_x};
    assign sum_y     = {1'b0, e3_cy} + {1'b0, cand_y};

    always_comb begin
        if (do_merge) begin
            out_entry = {sum_x[CB:1], sum_y[CB:1], s3_big_reg};
        end else if (do_append) begin
            out_entry = {cand_x, cand_y, cand_r};
        end else begin
            out_entry = s3_entry_reg;
        end
    end

    assign ev.record = do_merge || do_append;
    assign ev.merge  = do_merge;
    assign ev_idx    = s3_idx_reg;

    always_comb begin
        s1_vld_next = adv ? feed_vld   : s1_vld_reg;
        s2_vld_next = adv ? s1_vld_reg : s2_vld_reg;
        s3_vld_next = adv ? s2_vld_reg : s3_vld_reg;
        if (start) begin
            hit_next = 1'b0;
        end else if (adv && do_merge) begin
            hit_next = 1'b1;
        end else begin
            hit_next = hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_idx_reg   <= feed_idx;
            s1_entry_reg <= feed_entry;
            s2_idx_reg   <= s1_idx_reg;
            s2_entry_reg <= s1_entry_reg;
            s2_dx_reg    <= dx1[RFW-1:0];
            s2_dy_reg    <= dy1[RFW-1:0];
            s2_rfix_reg  <= rfix1;
            s2_big_reg   <= big1;
            s2_near_reg  <= near1;
            s3_idx_reg   <= s2_idx_reg;
            s3_entry_reg <= s2_entry_reg;
            s3_dx2_reg   <= dx2;
            s3_dy2_reg   <= dy2;
            s3_r2_reg    <= r2;
            s3_big_reg   <= s2_big_reg;
            s3_near_reg  <= s2_near_reg;
        end
    end

endmodule

>>> design/star_candidate_merge_table_top.sv
// Top level of the star candidate merge table: cell ring, merge unit, control.
// Depends on scmt_pkg, scmt_cell and scmt_merge_unit.
//
// The table lives in a ring of STAR_SLOTS cells, one entry per cell, with slot
// 0 at the head. A candidate beat on s_ is taken only when the block is idle;
// the ring then rotates once: each entry leaves the head cell, passes through
// the three-stage merge unit (distance, squares, decide) and re-enters at the
// tail, so when the sweep ends every entry is back in its own cell. The
// first valid entry within the larger radius is averaged with the candidate;
// with no hit, the candidate is written into the first free slot as it passes
// the merge unit; with no hit and no free slot it is dropped and table_full is
// flagged. clear_first empties the table (resets the count) before the search.
// Each candidate goes through an accept, the ring shifts of the sweep and a
// load of the result register, which may wait further on m_ready. The
// result register lets the next candidate be accepted while the previous
// result beat is still pending.
module star_candidate_merge_table_top #(
    parameter int STAR_SLOTS = 1024,
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_clear_first,
    input  logic [COORD_BITS-1:0]                      s_pos_x,
    input  logic [COORD_BITS-1:0]                      s_pos_y,
    input  logic [scmt_pkg::RADIUS_BITS-1:0]           s_cand_radius,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [((STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1)-1:0] m_entry_index,
    output logic                                       m_merged,
    output logic                                       m_table_full,
    output logic [COORD_BITS+FRAC_BITS-1:0]            m_center_x,
    output logic [COORD_BITS+FRAC_BITS-1:0]            m_center_y,
    output logic [scmt_pkg::RADIUS_BITS-1:0]           m_entry_radius,
    output logic [$clog2(STAR_SLOTS+1)-1:0]            m_entry_count
);
    import scmt_pkg::*;

    localparam int CB = COORD_BITS + FRAC_BITS;
    localparam int RB = RADIUS_BITS;
    localparam int IW = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1;
    localparam int CW = $clog2(STAR_SLOTS + 1);
    localparam int EW = 2 * CB + RB;
    localparam int SW = $clog2(STAR_SLOTS + 3);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;

    // candidate held for the whole sweep, already in fixed point
    logic [CB-1:0] cand_x_reg, cand_y_reg;
    logic [RB-1:0] cand_r_reg;

    // what the sweep produced
    logic          res_rec_reg, res_rec_next;
    logic          res_merge_reg, res_merge_next;
    logic [IW-1:0] res_idx_reg;
    logic [EW-1:0] res_entry_reg;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [IW-1:0] m_idx_reg;
    logic          m_merged_reg, m_full_reg;
    logic [CB-1:0] m_cx_reg, m_cy_reg;
    logic [RB-1:0] m_r_reg;
    logic [CW-1:0] m_count_reg;

    logic accept, adv, start, last_step, out_free;

    logic [EW-1:0] cell_q [STAR_SLOTS];
    logic [EW-1:0] cell_d [STAR_SLOTS];
    logic [EW-1:0] mu_out;
    scmt_event_t   mu_ev;
    logic [IW-1:0] mu_idx;

    logic [CB-1:0] res_cx, res_cy;
    logic [RB-1:0] res_r;
    assign {res_cx, res_cy, res_r} = res_entry_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign start     = accept;
    assign adv       = (state_reg == ST_SWEEP);
    assign last_step = (step_reg == SW'(STAR_SLOTS + 2));
    assign out_free  = !m_valid_reg || m_ready;

    // ring of cells: head feeds the merge unit, merge unit feeds the tail
    for (genvar i = 0; i < STAR_SLOTS; i++) begin : g_cell
        if (i == STAR_SLOTS - 1) begin : g_tail
            assign cell_d[i] = mu_out;
        end else begin : g_mid
            assign cell_d[i] = cell_q[i+1];
        end
        scmt_cell #(
            .ENTRY_BITS(EW)
        ) u_cell (
            .aclk    (aclk),
            .shift_en(adv),
            .d_in    (cell_d[i]),
            .q_out   (cell_q[i])
        );
    end

    scmt_merge_unit #(
        .STAR_SLOTS(STAR_SLOTS),
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .adv       (adv),
        .feed_vld  (step_reg < SW'(STAR_SLOTS)),
        .feed_idx  (step_reg[IW-1:0]),
        .feed_entry(cell_q[0]),
        .cand_x    (cand_x_reg),
        .cand_y    (cand_y_reg),
        .cand_r    (cand_r_reg),
        .count     (count_reg),
        .out_entry (mu_out),
        .ev        (mu_ev),
        .ev_idx    (mu_idx)
    );

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        res_rec_next   = res_rec_reg;
        res_merge_next = res_merge_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next     = ST_SWEEP;
                    step_next      = '0;
                    res_rec_next   = 1'b0;
                    res_merge_next = 1'b0;
                    if (s_clear_first) begin
                        count_next = '0;
                    end
                end
            end
            ST_SWEEP: begin
                step_next = step_reg + SW'(1);
                if (mu_ev.record) begin
                    res_rec_next   = 1'b1;
                    res_merge_next = mu_ev.merge;
                end
                if (last_step) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (res_rec_reg && !res_merge_reg) begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            res_rec_reg   <= 1'b0;
            res_merge_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            res_rec_reg   <= res_rec_next;
            res_merge_reg <= res_merge_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cand_x_reg <= CB'(s_pos_x) << FRAC_BITS;
            cand_y_reg <= CB'(s_pos_y) << FRAC_BITS;
            cand_r_reg <= s_cand_radius;
        end
        if (adv && mu_ev.record) begin
            res_idx_reg   <= mu_idx;
            res_entry_reg <= mu_out;
        end
        if (state_reg == ST_FLUSH && out_free) begin
            m_merged_reg <= res_merge_reg;
            m_full_reg   <= !res_rec_reg;
            m_idx_reg    <= res_rec_reg ? res_idx_reg : '0;
            m_cx_reg     <= res_rec_reg ? res_cx : '0;
            m_cy_reg     <= res_rec_reg ? res_cy : '0;
            m_r_reg      <= res_rec_reg ? res_r : '0;
            m_count_reg  <= (res_rec_reg && !res_merge_reg) ? count_reg + CW'(1) : count_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_entry_index  = m_idx_reg;
    assign m_merged       = m_merged_reg;
    assign m_table_full   = m_full_reg;
    assign m_center_x     = m_cx_reg;
    assign m_center_y     = m_cy_reg;
    assign m_entry_radius = m_r_reg;
    assign m_entry_count  = m_count_reg;

endmodule

>>> design/scmt_checker.sv
// Port-level checks for the star candidate merge table, bound to the top.
// Depends on scmt_pkg and star_candidate_merge_table_top.
module scmt_checker #(
    parameter int STAR_SLOTS = 1024,
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 8
) (
    input logic                                       aclk,
    input logic                                       aresetn,
    input logic                                       s_valid,
    input logic                                       s_ready,
    input logic                                       s_clear_first,
    input logic [COORD_BITS-1:0]                      s_pos_x,
    input logic [COORD_BITS-1:0]                      s_pos_y,
    input logic [scmt_pkg::RADIUS_BITS-1:0]           s_cand_radius,
    input logic                                       m_valid,
    input logic                                       m_ready,
    input logic [((STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1)-1:0] m_entry_index,
    input logic                                       m_merged,
    input logic                                       m_table_full,
    input logic [COORD_BITS+FRAC_BITS-1:0]            m_center_x,
    input logic [COORD_BITS+FRAC_BITS-1:0]            m_center_y,
    input logic [scmt_pkg::RADIUS_BITS-1:0]           m_entry_radius,
    input logic [$clog2(STAR_SLOTS+1)-1:0]            m_entry_count
);
    import scmt_pkg::*;

    // one candidate at a time: the beat after an accept is never taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a candidate is in flight");

    // a dropped candidate means a full table and no merge
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> !m_merged && (m_entry_count == STAR_SLOTS))
        else $error("drop reported without a full table");

    // a stored candidate sits in a valid slot
    a_index_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_table_full |-> (m_entry_index < m_entry_count))
        else $error("result slot beyond entry count");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_index)
            && $stable(m_center_x) && $stable(m_entry_count))
        else $error("result beat changed while stalled");

endmodule

bind star_candidate_merge_table_top scmt_checker #(
    .STAR_SLOTS(STAR_SLOTS),
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_scmt_checker (.*);

>>> tb/sv/star_candidate_merge_table_top_tb.sv
// Testbench for star_candidate_merge_table_top: random and directed candidate beats.
// Depends on scmt_pkg and the top level; scoreboard predicts every result beat.
`timescale 1ns / 100ps

module star_candidate_merge_table_top_tb;

    // Block configuration, kept at the defaults of the top level.
    localparam int SLOTS    = 1024;
    localparam int COORD_W  = 14;
    localparam int FRAC_W   = 8;
    localparam int CENTER_W = COORD_W + FRAC_W;
    localparam int RAD_W    = scmt_pkg::RADIUS_BITS;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // Settle time after the drain: room for one more pass through the ring and a drain allowance.
    localparam int SETTLE_CYCLES = SLOTS + 80;

    typedef struct packed {
        logic [IDX_W-1:0]    slot;
        logic                merged;
        logic                full;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [RAD_W-1:0]    radius;
        logic [CNT_W-1:0]    count;
    } merge_result_t;

    // Tracks the star table and holds the result beats still owed by the block.
    class star_table_tracker;
        logic [CENTER_W-1:0] cx_tab [SLOTS];
        logic [CENTER_W-1:0] cy_tab [SLOTS];
        logic [RAD_W-1:0]    rad_tab [SLOTS];
        int unsigned         live_count;
        merge_result_t       due_results [$];
        int                  errors;

        function new();
            live_count = 0;
            errors = 0;
        endfunction

        // Search for the first entry within the larger radius; merge, append or drop.
        function void merge_candidate(bit clear, bit [COORD_W-1:0] pos_x,
                                      bit [COORD_W-1:0] pos_y, bit [RAD_W-1:0] rad);
            longint unsigned px, py, big, rfix, dx, dy, cxo, cyo;
            merge_result_t   res;
            bit              hit;
            int              i;
            px = longint'(pos_x) << FRAC_W;
            py = longint'(pos_y) << FRAC_W;
            res = '0;
            hit = 0;
            if (clear)
                live_count = 0;
            i = 0;
            while (!hit && i < live_count) begin
                cxo = cx_tab[i];
                cyo = cy_tab[i];
                big = (rad_tab[i] > rad) ? rad_tab[i] : rad;
                rfix = big << FRAC_W;
                dx = (px >= cxo) ? px - cxo : cxo - px;
                dy = (py >= cyo) ? py - cyo : cyo - py;
                if (dx <= rfix && dy <= rfix && dx * dx + dy * dy <= rfix * rfix) begin
                    // average truncates: the half-LSB is lost
                    cx_tab[i]  = CENTER_W'((cxo + px) >> 1);
                    cy_tab[i]  = CENTER_W'((cyo + py) >> 1);
                    rad_tab[i] = RAD_W'(big);
                    hit = 1;
                    res.slot = IDX_W'(i);
                    res.merged = 1'b1;
                end else begin
                    i++;
                end
            end
            if (!hit) begin
                if (live_count < SLOTS) begin
                    res.slot = IDX_W'(live_count);
                    cx_tab[live_count]  = CENTER_W'(px);
                    cy_tab[live_count]  = CENTER_W'(py);
                    rad_tab[live_count] = rad;
                    live_count++;
                end else begin
                    res.full = 1'b1;
                end
            end
            if (!res.full) begin
                res.cx = cx_tab[res.slot];
                res.cy = cy_tab[res.slot];
                res.radius = rad_tab[res.slot];
            end
            res.count = CNT_W'(live_count);
            due_results.insert(due_results.size(), res);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result_beat(merge_result_t got);
            merge_result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: actual slot %0d count %0d",
                         $time, got.slot, got.count);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("entry_index", 64'(want.slot), 64'(got.slot));
            compare_field("merged", 64'(want.merged), 64'(got.merged));
            compare_field("table_full", 64'(want.full), 64'(got.full));
            compare_field("center_x", 64'(want.cx), 64'(got.cx));
            compare_field("center_y", 64'(want.cy), 64'(got.cy));
            compare_field("entry_radius", 64'(want.radius), 64'(got.radius));
            compare_field("entry_count", 64'(want.count), 64'(got.count));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_clear_first = 1'b0;
    logic [COORD_W-1:0]  s_pos_x = '0;
    logic [COORD_W-1:0]  s_pos_y = '0;
    logic [RAD_W-1:0]    s_cand_radius = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDX_W-1:0]    m_entry_index;
    logic                m_merged;
    logic                m_table_full;
    logic [CENTER_W-1:0] m_center_x;
    logic [CENTER_W-1:0] m_center_y;
    logic [RAD_W-1:0]    m_entry_radius;
    logic [CNT_W-1:0]    m_entry_count;

    // Set after an edge that took an input beat; the driver looks at it on the next falling edge.
    logic                in_fire = 1'b0;

    // Idle odds in percent for the two sides, changed per phase.
    int                  send_idle_pct = 0;
    int                  sink_stall_pct = 0;

    star_table_tracker   tracker = new();

    star_candidate_merge_table_top #(
        .STAR_SLOTS (SLOTS),
        .COORD_BITS (COORD_W),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_clear_first  (s_clear_first),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_cand_radius  (s_cand_radius),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_index  (m_entry_index),
        .m_merged       (m_merged),
        .m_table_full   (m_table_full),
        .m_center_x     (m_center_x),
        .m_center_y     (m_center_y),
        .m_entry_radius (m_entry_radius),
        .m_entry_count  (m_entry_count)
    );

    // 2 ns clock.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Receiver: ready changes on the falling edge with the current stall odds.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: both channels sampled at the rising edge, before the block updates.
    // Prediction goes first so a beat that lands on the same edge still finds its entry.
    always @(posedge aclk) begin
        merge_result_t got;
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.merge_candidate(s_clear_first, s_pos_x, s_pos_y, s_cand_radius);
            if (m_valid && m_ready) begin
                got.slot   = m_entry_index;
                got.merged = m_merged;
                got.full   = m_table_full;
                got.cx     = m_center_x;
                got.cy     = m_center_y;
                got.radius = m_entry_radius;
                got.count  = m_entry_count;
                tracker.check_result_beat(got);
            end
        end
    end

    // Present one candidate beat; called and returning on a falling edge.
    // Valid is dropped only when an idle gap is drawn, so back-to-back beats keep it high.
    task automatic send_candidate(input bit clear, input int x, input int y, input int rad);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_clear_first <= clear;
        s_pos_x       <= COORD_W'(x);
        s_pos_y       <= COORD_W'(y);
        s_cand_radius <= RAD_W'(rad);
        do
            @(negedge aclk);
        while (!in_fire);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // Corner cases: edges of the field, exact hits, zero radius, circle boundary,
    // truncating averages and first-match order.
    task automatic run_directed();
        send_candidate(1, 0, 0, 1);                  // append into empty table
        send_candidate(0, 0, 0, 255);                // exact hit, radius grows to max
        send_candidate(0, COORD_MAX, COORD_MAX, 255);
        send_candidate(0, COORD_MAX, COORD_MAX, 1);  // merge keeps larger radius
        // zero-radius candidates pulled in by the entry radius; the center walks
        // in halves so the fraction runs out and the average truncates
        send_candidate(0, COORD_MAX - 1, COORD_MAX, 0);
        send_candidate(0, COORD_MAX, COORD_MAX - 1, 0);
        send_candidate(0, COORD_MAX - 1, COORD_MAX - 1, 0);
        send_candidate(0, COORD_MAX, COORD_MAX, 0);
        send_candidate(0, COORD_MAX - 1, COORD_MAX, 0);
        send_candidate(0, COORD_MAX, COORD_MAX - 1, 0);
        send_candidate(0, COORD_MAX - 1, COORD_MAX - 1, 0);
        send_candidate(0, COORD_MAX, COORD_MAX, 0);
        send_candidate(0, COORD_MAX - 1, COORD_MAX, 0);
        send_candidate(0, COORD_MAX, COORD_MAX - 1, 0);
        // both radii zero: only an exact hit merges
        send_candidate(1, 100, 100, 0);
        send_candidate(0, 100, 100, 0);
        send_candidate(0, 101, 100, 0);
        // on the circle (3-4-5) merges; inside the box but off the circle appends
        send_candidate(1, 1000, 1000, 5);
        send_candidate(0, 1003, 1004, 5);
        send_candidate(0, 1500, 1500, 5);
        send_candidate(0, 1504, 1504, 5);
        // two entries cover the candidate: the lower slot wins
        send_candidate(1, 2000, 2000, 1);
        send_candidate(0, 2003, 2000, 1);
        send_candidate(0, 2002, 2000, 3);
    endtask

    // Fill every slot with far-apart candidates, then overflow: drops, and merges
    // into a full table.
    task automatic run_fill();
        int x0, y0, bx, by;
        x0 = 0;
        y0 = 0;
        for (int i = 0; i < SLOTS; i++) begin
            // cells 512 apart, jitter up to 255, radius up to 127: nothing merges
            bx = (i % 32) * 512 + $urandom_range(255);
            by = (i / 32) * 512 + $urandom_range(255);
            if (i == 0) begin
                x0 = bx;
                y0 = by;
            end
            send_candidate(i == 0, bx, by, $urandom_range(127, 1));
        end
        for (int k = 0; k < 4; k++) begin
            // between cells: at least 128 away from every entry in both axes
            send_candidate(0, 384 + 512 * $urandom_range(30), 384 + 512 * $urandom_range(30), 1);
        end
        send_candidate(0, x0, y0, 1);
        for (int k = 0; k < 4; k++)
            send_candidate(0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(255));
    endtask

    // Frames open with a clear, then candidates clustered around a few stars
    // with noise mixed in.
    task automatic run_random(input int n_items);
        int sx [8];
        int sy [8];
        int sent, frame_left, stars, pick, jit, x, y, rad;
        bit clr;
        sent = 0;
        frame_left = 0;
        stars = 1;
        while (sent < n_items) begin
            clr = 0;
            if (frame_left == 0) begin
                clr = 1;
                frame_left = $urandom_range(60, 4);
                stars = $urandom_range(6, 1);
                for (int k = 0; k < stars; k++) begin
                    case ($urandom_range(9))
                        0: sx[k] = 0;
                        1: sx[k] = COORD_MAX;
                        default: sx[k] = $urandom_range(COORD_MAX);
                    endcase
                    case ($urandom_range(9))
                        0: sy[k] = 0;
                        1: sy[k] = COORD_MAX;
                        default: sy[k] = $urandom_range(COORD_MAX);
                    endcase
                end
            end else if ($urandom_range(99) == 0) begin
                clr = 1;    // stray clear inside a frame
            end
            if ($urandom_range(99) < 85) begin
                pick = $urandom_range(stars - 1);
                rad = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(40, 1);
                jit = rad + 2;
                x = clamp_coord(sx[pick] + $urandom_range(2 * jit) - jit);
                y = clamp_coord(sy[pick] + $urandom_range(2 * jit) - jit);
            end else begin
                x = $urandom_range(COORD_MAX);
                y = $urandom_range(COORD_MAX);
                rad = $urandom_range(255);
            end
            send_candidate(clr, x, y, rad);
            sent++;
            frame_left--;
        end
    endtask

    task automatic set_idling(input int send_pct, input int sink_pct);
        send_idle_pct = send_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Filling the table alone takes SLOTS beats, so the other phases stay short.
        set_idling(0, 0);
        run_directed();
        set_idling(77, 0);
        run_fill();
        set_idling(0, 77);
        run_random(60);
        set_idling(38, 38);
        run_random(60);
        s_valid <= 1'b0;

        // Drain, then leave room for any stray beat the block might still emit.
        while (tracker.due_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: limit set well above the expected run time.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
